### hdl/vector_normalize_top_assert.svh
// ----------------------------------------------------------------------------
// Vector normalize assertion macros
// Shared assertion forms for the vector normalize checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR_NORMALIZE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vn_pkg.sv
// ----------------------------------------------------------------------------
// Vector normalize package
// Request, response and internal queue types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

   localparam int NUM_COMP   = 5;
   localparam int COMP_W     = 16;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 32;
   localparam int SUM_W      = 35;
   localparam int LEN_W      = 25;
   localparam int UNIT_W     = 16;
   localparam int QUO_STEPS  = 29;
   localparam int ROOT_STEPS = 15;
   localparam int LEN_STEPS  = 26;
   localparam logic [2:0] DIMS_MIN = 3'd2;
   localparam logic [2:0] DIMS_MAX = 3'd5;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef struct packed {
      logic [2:0]               dims;
      logic signed [COMP_W-1:0] comp0;
      logic signed [COMP_W-1:0] comp1;
      logic signed [COMP_W-1:0] comp2;
      logic signed [COMP_W-1:0] comp3;
      logic signed [COMP_W-1:0] comp4;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]         length;
      logic signed [UNIT_W-1:0] unit0;
      logic signed [UNIT_W-1:0] unit1;
      logic signed [UNIT_W-1:0] unit2;
      logic signed [UNIT_W-1:0] unit3;
      logic signed [UNIT_W-1:0] unit4;
      logic                     zero_vector;
   } rsp_type;

   typedef struct packed {
      logic [NUM_COMP-1:0][SQ_W-1:0] sq;
      logic [NUM_COMP-1:0]           neg;
   } sq_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

### hdl/vn_front.sv
// ----------------------------------------------------------------------------
// Vector normalize front end
// Accepts requests, takes component magnitudes and signs, and squares them.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_front #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire vn_pkg::req_type      req_data,
   input  wire vn_pkg::q_status_type q_stat,
   output logic                      q_push,
   output vn_pkg::sq_item_type       q_data
);

   localparam int SB = (COMPONENT_BITS > vn_pkg::COMP_W) ? vn_pkg::COMP_W : COMPONENT_BITS;
   localparam logic [vn_pkg::COMP_W:0] MODV = (vn_pkg::COMP_W + 1)'(1) << SB;
   localparam logic [vn_pkg::COMP_W-1:0] MASK = vn_pkg::COMP_W'(MODV - 1'b1);
   localparam logic SIGNED_IN = (COMPONENT_BITS <= vn_pkg::COMP_W);

   logic                                              a_v_ff, a_v_in, b_v_ff, b_v_in;
   logic [vn_pkg::NUM_COMP-1:0][vn_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic [vn_pkg::NUM_COMP-1:0]                       neg_ff, neg_in;
   vn_pkg::sq_item_type                               sq_ff, sq_in;
   logic [vn_pkg::NUM_COMP-1:0][vn_pkg::COMP_W-1:0]   comps;
   logic [2:0]                                        n_used;
   logic                                              a_adv, b_adv, accept;

   assign b_adv    = !b_v_ff || !q_stat.full;
   assign a_adv    = !a_v_ff || b_adv;
   assign req_full = !a_adv;
   assign accept   = req_push && !req_full;
   assign q_push   = b_v_ff && !q_stat.full;
   assign q_data   = sq_ff;

   assign comps = {req_data.comp4, req_data.comp3, req_data.comp2,
                   req_data.comp1, req_data.comp0};

   always_comb begin
      logic [vn_pkg::COMP_W-1:0] raw;
      logic [vn_pkg::COMP_W:0]   flip;
      logic                      sgn;
      if (req_data.dims < vn_pkg::DIMS_MIN) begin
         n_used = vn_pkg::DIMS_MIN;
      end else if (req_data.dims > vn_pkg::DIMS_MAX) begin
         n_used = vn_pkg::DIMS_MAX;
      end else begin
         n_used = req_data.dims;
      end
      a_v_in = accept ? 1'b1 : (a_adv ? 1'b0 : a_v_ff);
      b_v_in = b_adv ? a_v_ff : b_v_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      for (int i = 0; i < vn_pkg::NUM_COMP; i++) begin
         raw  = comps[i] & MASK;
         sgn  = SIGNED_IN && raw[SB-1];
         flip = MODV - {1'b0, raw};
         if (3'(i) >= n_used) begin
            mag_in[i] = '0;
            neg_in[i] = 1'b0;
         end else begin
            mag_in[i] = sgn ? flip[vn_pkg::MAG_W-1:0] : raw;
            neg_in[i] = sgn;
         end
      end
      sq_in = sq_ff;
      for (int i = 0; i < vn_pkg::NUM_COMP; i++) begin
         sq_in.sq[i] = vn_pkg::SQ_W'(mag_ff[i] * mag_ff[i]);
      end
      sq_in.neg = neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (b_adv) begin
         sq_ff <= sq_in;
      end
   end

endmodule

`default_nettype wire

### hdl/vn_queue.sv
// ----------------------------------------------------------------------------
// Vector normalize queue
// Short register queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire vn_pkg::sq_item_type wr_data,
   input  wire logic                pop,
   output vn_pkg::q_status_type     stat,
   output vn_pkg::sq_item_type      rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULLC = CW'(DEPTH);

   vn_pkg::sq_item_type entry_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == FULLC);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign rd_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### hdl/vn_back.sv
// ----------------------------------------------------------------------------
// Vector normalize back end
// Pipelined length root, per-component restoring divide and unit root.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vn_pkg::q_status_type q_stat,
   input  wire vn_pkg::sq_item_type  q_data,
   output logic                      q_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output vn_pkg::rsp_type           rsp_data
);

   localparam int NC  = vn_pkg::NUM_COMP;
   localparam int SW  = vn_pkg::SUM_W;
   localparam int NST = vn_pkg::QUO_STEPS + vn_pkg::ROOT_STEPS;
   localparam int RW  = vn_pkg::ROOT_STEPS;
   localparam int LRW = vn_pkg::LEN_STEPS;

   typedef struct packed {
      logic [SW-1:0]                sum;
      logic                         zero;
      logic [NC-1:0]                neg;
      logic [NC-1:0][SW-1:0]        drem;
      logic [NC-1:0]                dnext;
      logic [NC-1:0][2*RW-1:0]      quo;
      logic [NC-1:0][RW+1:0]        srem;
      logic [NC-1:0][RW-1:0]        root;
      logic [2*LRW-1:0]             lrad;
      logic [LRW+1:0]               lrem;
      logic [LRW-1:0]               lroot;
   } stage_type;

   stage_type         st_ff [NST+1];
   stage_type         s0_in;
   logic [NST:0]      v_ff;
   logic              out_v_ff;
   vn_pkg::rsp_type   rsp_ff, rsp_in;
   logic              adv;

   // One step of every lane: a divide step or a root step on the quotient,
   // plus a root step on the length while it is still being formed.
   function automatic stage_type step_f(stage_type p, logic do_div, logic do_len);
      stage_type          n;
      logic [SW:0]        r;
      logic [RW+3:0]      r2;
      logic [RW+1:0]      tr;
      logic [LRW+3:0]     lr2;
      logic [LRW+1:0]     ltr;
      n = p;
      for (int i = 0; i < NC; i++) begin
         if (do_div) begin
            r = {p.drem[i], p.dnext[i]};
            if (r >= {1'b0, p.sum}) begin
               n.drem[i] = SW'(r - {1'b0, p.sum});
               n.quo[i]  = {p.quo[i][2*RW-2:0], 1'b1};
            end else begin
               n.drem[i] = r[SW-1:0];
               n.quo[i]  = {p.quo[i][2*RW-2:0], 1'b0};
            end
            n.dnext[i] = 1'b0;
         end else begin
            r2 = {p.srem[i], p.quo[i][2*RW-1:2*RW-2]};
            tr = {p.root[i], 2'b01};
            if (r2 >= {2'b00, tr}) begin
               n.srem[i] = (RW + 2)'(r2 - {2'b00, tr});
               n.root[i] = {p.root[i][RW-2:0], 1'b1};
            end else begin
               n.srem[i] = r2[RW+1:0];
               n.root[i] = {p.root[i][RW-2:0], 1'b0};
            end
            n.quo[i] = {p.quo[i][2*RW-3:0], 2'b00};
         end
      end
      if (do_len) begin
         lr2 = {p.lrem, p.lrad[2*LRW-1:2*LRW-2]};
         ltr = {p.lroot, 2'b01};
         if (lr2 >= {2'b00, ltr}) begin
            n.lrem  = (LRW + 2)'(lr2 - {2'b00, ltr});
            n.lroot = {p.lroot[LRW-2:0], 1'b1};
         end else begin
            n.lrem  = lr2[LRW+1:0];
            n.lroot = {p.lroot[LRW-2:0], 1'b0};
         end
         n.lrad = {p.lrad[2*LRW-3:0], 2'b00};
      end
      return n;
   endfunction

   assign adv       = !out_v_ff || rsp_pop;
   assign q_pop     = adv && q_stat.valid;
   assign rsp_empty = !out_v_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [SW-1:0] acc;
      acc = '0;
      for (int i = 0; i < NC; i++) begin
         acc = acc + SW'(q_data.sq[i]);
      end
      s0_in       = '0;
      s0_in.sum   = acc;
      s0_in.zero  = (acc == '0);
      s0_in.neg   = q_data.neg;
      // The divide starts from the square over two; its low bit is the
      // first dividend bit brought down.
      for (int i = 0; i < NC; i++) begin
         s0_in.drem[i]  = SW'(q_data.sq[i] >> 1);
         s0_in.dnext[i] = q_data.sq[i][0];
      end
      s0_in.lrad = (2 * LRW)'({acc, 16'h0000});
   end

   always_comb begin
      stage_type               last;
      logic [vn_pkg::UNIT_W-1:0] u;
      logic [vn_pkg::UNIT_W-1:0] units [NC];
      last = st_ff[NST];
      for (int i = 0; i < NC; i++) begin
         u = vn_pkg::UNIT_W'(last.root[i]);
         units[i] = last.zero ? '0 : (last.neg[i] ? (vn_pkg::UNIT_W'(0) - u) : u);
      end
      rsp_in.unit0 = units[0];
      rsp_in.unit1 = units[1];
      rsp_in.unit2 = units[2];
      rsp_in.unit3 = units[3];
      rsp_in.unit4 = units[4];
      rsp_in.zero_vector = last.zero;
      if (last.zero) begin
         rsp_in.length = '0;
      end else if (last.lroot > LRW'(vn_pkg::LEN_MAX)) begin
         rsp_in.length = vn_pkg::LEN_MAX;
      end else begin
         rsp_in.length = last.lroot[vn_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[NST-1:0], q_stat.valid};
         out_v_ff <= v_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= s0_in;
         rsp_ff   <= rsp_in;
      end
   end

   for (genvar k = 1; k <= NST; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= step_f(st_ff[k-1], 1'(k <= vn_pkg::QUO_STEPS),
                               1'(k <= vn_pkg::LEN_STEPS));
         end
      end
   end

endmodule

`default_nettype wire

### hdl/vector_normalize_top.sv
// Throughput: one request per cycle, set by the 44-step pipelined divide and
// root of the back end, which advances whenever the response register is free.
// Reset: synchronous and active high; it empties the front end, the queue
// and the pipeline valid bits, so no response is shown afterward.
// ----------------------------------------------------------------------------
// Vector normalize top level
// Euclidean length and unit vector of a two- to five-component vector.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalize_top #(
   parameter int COMPONENT_BITS = 16,
   parameter int QUEUE_DEPTH    = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire vn_pkg::req_type req_data,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output vn_pkg::rsp_type      rsp_data
);

   vn_pkg::q_status_type q_stat;
   vn_pkg::sq_item_type  q_wr_data, q_rd_data;
   logic                 q_push, q_pop;

   vn_front #(
      .COMPONENT_BITS(COMPONENT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   vn_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .stat    (q_stat),
      .rd_data (q_rd_data)
   );

   vn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/vn_checker.sv
// ----------------------------------------------------------------------------
// Vector normalize checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_normalize_top_assert.svh"

module vn_checker (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_empty,
   input wire logic            rsp_pop,
   input wire vn_pkg::rsp_type rsp_data
);

   `VN_ASSERT_NXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "stalled response changed")
   `VN_ASSERT_IMP(a_zero_out, clock, reset, !rsp_empty && rsp_data.zero_vector, rsp_data.length == '0 && rsp_data.unit0 == '0 && rsp_data.unit1 == '0 && rsp_data.unit4 == '0, "zero vector with nonzero outputs")
   `VN_ASSERT_IMP(a_len_min, clock, reset, !rsp_empty && !rsp_data.zero_vector, rsp_data.length >= 25'd256, "nonzero vector shorter than one")
   `VN_ASSERT_IMP(a_unit_rng, clock, reset, !rsp_empty, rsp_data.unit0 <= 16'sd16384 && rsp_data.unit0 >= -16'sd16384, "unit component out of range")

endmodule

bind vector_normalize_top vn_checker u_vn_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### test/vector_normalize_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector normalize checker
// Watches both channels of the block. Every accepted request is turned into
// its expected length and unit vector, which are compared with each popped
// response as a whole, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalize_checker (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   input  wire logic            req_full,
   input  wire vn_pkg::req_type req_data,
   input  wire logic            rsp_empty,
   input  wire logic            rsp_pop,
   input  wire vn_pkg::rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count
);

   vn_pkg::rsp_type expected_vectors[$];

   // Length is floor(256 * L) and each unit is trunc(16384 * c / L), both from
   // the exact sum of squares, worked out by bitwise square-root searches.
   function automatic vn_pkg::rsp_type normalize_vector(vn_pkg::req_type v);
      logic signed [vn_pkg::COMP_W-1:0] comp[vn_pkg::NUM_COMP];
      logic [63:0]     mag[vn_pkg::NUM_COMP];
      logic            neg[vn_pkg::NUM_COMP];
      logic [15:0]     unit[vn_pkg::NUM_COMP];
      logic [63:0]     sum, root, t, q, rhs;
      int              n;
      vn_pkg::rsp_type r;
      comp = '{v.comp0, v.comp1, v.comp2, v.comp3, v.comp4};
      n = (v.dims < vn_pkg::DIMS_MIN) ? int'(vn_pkg::DIMS_MIN) :
          (v.dims > vn_pkg::DIMS_MAX) ? int'(vn_pkg::DIMS_MAX) : int'(v.dims);
      r = '0;
      sum = 0;
      for (int i = 0; i < vn_pkg::NUM_COMP; i++) begin
         neg[i] = comp[i] < 0;
         mag[i] = neg[i] ? 64'(-int'(comp[i])) : 64'(int'(comp[i]));
         unit[i] = '0;
         if (i < n) sum += mag[i] * mag[i];
      end
      if (sum == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         t = root | (64'd1 << b);
         if (t * t <= (sum << 16)) root = t;
      end
      r.length = (root > 64'(vn_pkg::LEN_MAX)) ? vn_pkg::LEN_MAX : root[vn_pkg::LEN_W-1:0];
      for (int i = 0; i < n; i++) begin
         rhs = (mag[i] * mag[i]) << 28;
         q = 0;
         for (int b = 14; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t <= 64'd16384 && sum * t * t <= rhs) q = t;
         end
         unit[i] = neg[i] ? 16'(-q) : q[15:0];
      end
      r.unit0 = unit[0];
      r.unit1 = unit[1];
      r.unit2 = unit[2];
      r.unit3 = unit[3];
      r.unit4 = unit[4];
      return r;
   endfunction

   assign pending_count = expected_vectors.size();

   always @(posedge clock) begin
      vn_pkg::rsp_type want;
      if (reset) begin
         expected_vectors.delete();
         error_count <= 0;
      end else begin
         if (req_push && !req_full) expected_vectors.push_back(normalize_vector(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (expected_vectors.size() == 0) begin
               error_count <= error_count + 1;
               $display("%0t: response with no request waiting: %p", $time, rsp_data);
            end else begin
               want = expected_vectors.pop_front();
               if (want !== rsp_data) begin
                  error_count <= error_count + 1;
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector normalize testbench
// Drives directed and random vectors into the block under random stalls on
// both sides and leaves the comparison of responses to the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int IDLE_LIMIT  = 3000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 80;
   localparam int RANDOM_REQS = 2000;

   logic            clock;
   logic            reset;
   logic            req_push;
   logic            req_full;
   vn_pkg::req_type req_data;
   logic            rsp_empty;
   logic            rsp_pop;
   vn_pkg::rsp_type rsp_data;
   int              error_count;
   int              pending_count;
   logic            hold_responses;
   int              idle_cycles;

   vector_normalize_top uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   vector_normalize_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         3: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic vn_pkg::req_type make_vector(logic [2:0] dims, logic [15:0] c0,
                                                   logic [15:0] c1, logic [15:0] c2,
                                                   logic [15:0] c3, logic [15:0] c4);
      vn_pkg::req_type v;
      v.dims = dims;
      v.comp0 = c0;
      v.comp1 = c1;
      v.comp2 = c2;
      v.comp3 = c3;
      v.comp4 = c4;
      return v;
   endfunction

   // Keeps push high across back-to-back requests; lowers it only for a gap.
   task automatic send_request(vn_pkg::req_type v);
      int gap;
      req_push <= 1'b1;
      req_data <= v;
      @(posedge clock);
      while (req_full) @(posedge clock);
      gap = random_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: random pops, short and long stalls, and a long hold-off
   // on request from the stimulus.
   initial begin
      int stall;
      stall = 0;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_responses) begin
            hold_responses <= 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= 1'b0;
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      vn_pkg::req_type v;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      hold_responses = 1'b0;
      idle_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero vectors, every dims code including out of range.
      send_request(make_vector(3'd2, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_request(make_vector(3'd5, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_request(make_vector(3'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_request(make_vector(3'd3, 16'd0, 16'd0, 16'd0, 16'h1234, 16'h8000));
      send_request(make_vector(3'd2, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'd1));
      send_request(make_vector(3'd4, 16'd3, 16'd4, 16'd0, 16'd0, 16'h7FFF));
      send_request(make_vector(3'd2, 16'd0, 16'hFFFF, 16'd5, 16'd5, 16'd5));
      send_request(make_vector(3'd0, 16'd1, 16'd1, 16'h7FFF, 16'd9, 16'd9));
      send_request(make_vector(3'd1, 16'hFFFF, 16'd0, 16'h8000, 16'd9, 16'd9));
      send_request(make_vector(3'd6, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5));
      send_request(make_vector(3'd7, 16'h8000, 16'd2, 16'hFFFD, 16'd4, 16'h7FFF));
      send_request(make_vector(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_vector(3'd4, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'd0));
      send_request(make_vector(3'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1));

      // Waits until everything has come back; push is left as the last request set it.
      wait (pending_count == 0);
      @(posedge clock);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         v = make_vector(($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 5)),
                         random_component(), random_component(), random_component(),
                         random_component(), random_component());
         if ($urandom_range(0, 29) == 0) begin
            v.comp0 = '0;
            v.comp1 = '0;
            if (v.dims > 2) v.comp2 = '0;
            if (v.dims > 3) v.comp3 = '0;
            if (v.dims > 4) v.comp4 = '0;
         end
         // Long hold-off on the response side while requests keep coming.
         if (i == 500) hold_responses <= 1'b1;
         if (i == 1200) begin
            req_push <= 1'b0;
            wait (pending_count == 0);
            @(posedge clock);
         end
         send_request(v);
      end
      req_push <= 1'b0;

      wait (pending_count == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
